// ===== hw/rtl/brld_pkg.sv =====
// Package with the types, codes and constants of the bitmap run-length decoder.
package brld_pkg;

	// Request types carried by an input transaction.
	localparam logic REQ_PUSH_BYTE = 1'b0;
	localparam logic REQ_PULL_WORD = 1'b1;

	// Status codes returned with every result.
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_WRONG_REQ = 2'd1;
	localparam logic [1:0] ST_CLIPPED   = 2'd2;

	// Run kinds held in the two low bits of a run code.
	localparam logic [1:0] KIND_SKIP = 2'd0;
	localparam logic [1:0] KIND_BYTE = 2'd1;
	localparam logic [1:0] KIND_WORD = 2'd2;
	localparam logic [1:0] KIND_LIT  = 2'd3;

	// Header byte ranges of a variable-length value.
	localparam logic [7:0] HDR_SHORT_MAX = 8'd223;
	localparam logic [7:0] HDR_EXT_BASE  = 8'd224;
	localparam logic [7:0] HDR_EXT_MAX   = 8'd254;

	// Bytes in one assembled word.
	localparam logic [2:0] WORD_BYTES = 3'd4;

	typedef enum logic [2:0] {
		PH_HDR       = 3'd0,
		PH_EXT_SHORT = 3'd1,
		PH_EXT_LONG  = 3'd2,
		PH_FILL_BYTE = 3'd3,
		PH_FILL_WORD = 3'd4,
		PH_LIT_WORD  = 3'd5,
		PH_EMIT      = 3'd6
	} phase_t;

	typedef struct packed {
		logic       req_type;
		logic [7:0] in_byte;
	} in_t;

	typedef struct packed {
		logic        word_valid;
		logic [31:0] out_word;
		logic        last_word;
		logic        need_byte;
		logic [1:0]  status;
	} out_t;

	typedef struct packed {
		phase_t      phase;
		logic [31:0] assembly;
		logic [2:0]  bytes_left;
		logic        header_target;
		logic [31:0] words_remaining;
		logic [29:0] run_left;
		logic [1:0]  run_kind;
		logic [31:0] fill_word;
	} dec_state_t;

	localparam dec_state_t STATE_RESET = '{
		phase:           PH_HDR,
		assembly:        32'd0,
		bytes_left:      3'd0,
		header_target:   1'b0,
		words_remaining: 32'd0,
		run_left:        30'd0,
		run_kind:        2'd0,
		fill_word:       32'd0
	};

endpackage

// ===== hw/rtl/brld_step.sv =====
// Combinational decode step: one transaction against the current decoder state.
module brld_step (
	input  brld_pkg::dec_state_t cur,
	input  brld_pkg::in_t        item,
	input  logic                 big_endian,
	output brld_pkg::dec_state_t nxt,
	output brld_pkg::out_t       res
);
	import brld_pkg::*;

	logic [31:0] asm4;
	logic [2:0]  bl4;
	logic        done4;
	logic        vd;
	logic [31:0] vval;
	logic [31:0] len32;
	logic        clip;
	logic        emitting;
	logic        wrong;
	logic [31:0] wr_dec;

	// Four-byte assembly shared by the long header, fill word and literal words.
	always_comb begin
		if (big_endian) begin
			asm4 = {cur.assembly[23:0], item.in_byte};
		end else begin
			asm4 = {item.in_byte, cur.assembly[31:8]};
		end
		bl4   = (cur.bytes_left != 3'd0) ? cur.bytes_left - 3'd1 : 3'd0;
		done4 = (bl4 == 3'd0);
	end

	// Next-state logic.
	always_comb begin
		nxt   = cur;
		vd    = 1'b0;
		vval  = 32'd0;
		len32 = 32'd0;
		clip  = 1'b0;
		unique case (cur.phase)
			PH_EMIT: begin
				if (item.req_type == REQ_PULL_WORD) begin
					if (cur.run_left != 30'd0) begin
						nxt.run_left = cur.run_left - 30'd1;
					end
					if (cur.words_remaining != 32'd0) begin
						nxt.words_remaining = cur.words_remaining - 32'd1;
					end
					if (nxt.words_remaining == 32'd0) begin
						nxt.phase         = PH_HDR;
						nxt.header_target = 1'b0;
						nxt.run_left      = 30'd0;
					end else if (nxt.run_left == 30'd0) begin
						nxt.phase = PH_HDR;
					end else if (cur.run_kind == KIND_LIT) begin
						nxt.phase      = PH_LIT_WORD;
						nxt.assembly   = 32'd0;
						nxt.bytes_left = WORD_BYTES;
					end
				end
			end
			PH_HDR: begin
				if (item.req_type == REQ_PUSH_BYTE) begin
					if (item.in_byte <= HDR_SHORT_MAX) begin
						vd   = 1'b1;
						vval = {24'd0, item.in_byte};
					end else if (item.in_byte <= HDR_EXT_MAX) begin
						nxt.assembly   = {24'd0, item.in_byte - HDR_EXT_BASE};
						nxt.bytes_left = 3'd1;
						nxt.phase      = PH_EXT_SHORT;
					end else begin
						nxt.phase      = PH_EXT_LONG;
						nxt.assembly   = 32'd0;
						nxt.bytes_left = WORD_BYTES;
					end
				end
			end
			PH_EXT_SHORT: begin
				if (item.req_type == REQ_PUSH_BYTE) begin
					nxt.bytes_left = 3'd0;
					vd             = 1'b1;
					vval           = {cur.assembly[23:0], item.in_byte};
				end
			end
			PH_EXT_LONG: begin
				if (item.req_type == REQ_PUSH_BYTE) begin
					nxt.assembly   = asm4;
					nxt.bytes_left = bl4;
					vd             = done4;
					vval           = asm4;
				end
			end
			PH_FILL_BYTE: begin
				if (item.req_type == REQ_PUSH_BYTE) begin
					nxt.fill_word = {4{item.in_byte}};
					nxt.phase     = (cur.run_left != 30'd0) ? PH_EMIT : PH_HDR;
				end
			end
			PH_FILL_WORD: begin
				if (item.req_type == REQ_PUSH_BYTE) begin
					nxt.assembly   = asm4;
					nxt.bytes_left = bl4;
					if (done4) begin
						nxt.fill_word = asm4;
						nxt.phase     = (cur.run_left != 30'd0) ? PH_EMIT : PH_HDR;
					end
				end
			end
			PH_LIT_WORD: begin
				if (item.req_type == REQ_PUSH_BYTE) begin
					nxt.assembly   = asm4;
					nxt.bytes_left = bl4;
					if (done4) begin
						nxt.fill_word = asm4;
						nxt.phase     = PH_EMIT;
					end
				end
			end
			default: begin
				nxt.phase = PH_HDR;
			end
		endcase

		// A completed variable-length value is either the word count or a run code.
		if (vd) begin
			nxt.phase = PH_HDR;
			if (!cur.header_target) begin
				nxt.words_remaining = vval;
				nxt.header_target   = (vval != 32'd0);
			end else begin
				len32 = {2'b00, vval[31:2]};
				if (len32 > cur.words_remaining) begin
					len32 = cur.words_remaining;
					clip  = 1'b1;
				end
				nxt.run_left = len32[29:0];
				nxt.run_kind = vval[1:0];
				case (vval[1:0])
					KIND_SKIP: begin
						nxt.phase = (nxt.run_left != 30'd0) ? PH_EMIT : PH_HDR;
					end
					KIND_BYTE: begin
						nxt.phase = PH_FILL_BYTE;
					end
					KIND_WORD: begin
						nxt.phase      = PH_FILL_WORD;
						nxt.assembly   = 32'd0;
						nxt.bytes_left = WORD_BYTES;
					end
					default: begin
						if (nxt.run_left != 30'd0) begin
							nxt.phase      = PH_LIT_WORD;
							nxt.assembly   = 32'd0;
							nxt.bytes_left = WORD_BYTES;
						end
					end
				endcase
			end
		end
	end

	// Result logic.
	always_comb begin
		emitting = (cur.phase == PH_EMIT) && (item.req_type == REQ_PULL_WORD);
		wrong    = (cur.phase == PH_EMIT) ? (item.req_type == REQ_PUSH_BYTE)
		                                  : (item.req_type == REQ_PULL_WORD);
		wr_dec   = (cur.words_remaining != 32'd0) ? cur.words_remaining - 32'd1 : 32'd0;

		res.word_valid = emitting;
		res.out_word   = (emitting && cur.run_kind != KIND_SKIP) ? cur.fill_word : 32'd0;
		res.last_word  = emitting && (wr_dec == 32'd0);
		res.need_byte  = (nxt.phase != PH_EMIT);
		if (wrong) begin
			res.status = ST_WRONG_REQ;
		end else if (clip) begin
			res.status = ST_CLIPPED;
		end else begin
			res.status = ST_OK;
		end
	end

endmodule

// ===== hw/rtl/bitmap_run_length_decoder_core.sv =====
// Top level of the bitmap run-length decoder: channel registers and decoder state.
//
// The block decodes a run-length coded bitmap. Each input transaction either
// pushes one coded byte (req_type 0) or pulls one decoded 32-bit word
// (req_type 1), and every input transaction yields exactly one result
// transaction carrying the word (if any), a last-word flag, need_byte and a
// status code. A request of the wrong type is answered with a status and
// leaves the decoder untouched, so the user may watch need_byte to pick the
// next request.
// An accepted transaction is held in the input register, the decode step
// then runs in combinational logic and its result is captured in the output
// register when the item moves on, so each result passes through both
// registers; one transaction can be taken every cycle while the receiver
// does not stall.
// When the receiver stalls, the output register holds its result, the input
// register may still fill, and in_ready drops only once both are occupied.
// cfg_we writes the word byte order (cfg_wdata 1 is most significant byte
// first); it is only to be written while the block holds no transaction.
// Asynchronous reset empties both registers, selects most significant byte
// first and sets the decoder to expect a new word count.
module bitmap_run_length_decoder_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  brld_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output brld_pkg::out_t out_data,
	input  logic           cfg_we,
	input  logic           cfg_wdata
);
	import brld_pkg::*;

	in_t        item_s1;
	logic       item_vld_s1;
	dec_state_t state_q;
	dec_state_t state_nxt;
	out_t       res_nxt;
	out_t       res_q;
	logic       res_vld_q;
	logic       big_endian_q;
	logic       out_free;
	logic       advance;

	// The output register can take a new result when it is empty or being drained.
	assign out_free  = !res_vld_q || out_ready;
	// The item in the input register is decoded in the cycle it moves on.
	assign advance   = item_vld_s1 && out_free;
	assign in_ready  = !item_vld_s1 || out_free;
	assign out_valid = res_vld_q;
	assign out_data  = res_q;

	brld_step u_step (
		.cur        (state_q),
		.item       (item_s1),
		.big_endian (big_endian_q),
		.nxt        (state_nxt),
		.res        (res_nxt)
	);

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			big_endian_q <= 1'b1;
		end else if (cfg_we) begin
			big_endian_q <= cfg_wdata;
		end
	end

	// Input register stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_vld_s1 <= 1'b0;
		end else if (in_ready) begin
			item_vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	// Decoder state advances once per decoded transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (out_free) begin
			res_vld_q <= advance;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

endmodule
